### rtl/ssc_pkg.sv
// Shared types and constants for the same-size convolution block.
package ssc_pkg;

    // Field widths fixed by the interface.
    localparam int LEN_W    = 7;
    localparam int IDX_W    = LEN_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int RESULT_W = 38;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORRELATE_MODE = 2'd1;

    // Configuration seen by the front end.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             corr;
    } cfg_t;

    // One row job handed from the front end to the engine.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] half;
        logic             corr;
    } job_t;

    // Engine status toward the top level.
    typedef struct packed {
        logic busy;
        logic pop;
    } eng_status_t;

endpackage

### rtl/ssc_front.sv
// Front end: accepts sample pairs, stores them and issues a job at row end.
module ssc_front #(
    parameter int MAX_LEN = 64,
    parameter int ADDR_W  = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ssc_pkg::cfg_t                        cfg,
    input  logic                                 hold,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  operator_sample,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  record_sample,
    output logic                                 wr_en,
    output logic [ADDR_W-1:0]                    wr_addr,
    output logic signed [ssc_pkg::SAMPLE_W-1:0]  wr_op,
    output logic signed [ssc_pkg::SAMPLE_W-1:0]  wr_rec,
    output logic                                 job_push,
    output ssc_pkg::job_t                        job
);
    import ssc_pkg::*;

    localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);

    logic [LEN_W-1:0] load_count_reg;
    logic [LEN_W-1:0] load_count_next;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] pos_inc;
    logic             accept;
    logic             row_done;

    // Lengths outside the legal range are clamped.
    always_comb
    begin
        if (cfg.len < LEN_W'(2))
            eff_len = LEN_W'(2);
        else if (cfg.len > MAX_L)
            eff_len = MAX_L;
        else
            eff_len = cfg.len;
    end

    assign item_stall = hold;
    assign accept     = item_valid && !item_stall;

    // Store position, kept inside the sample stores.
    assign pos      = (load_count_reg >= MAX_L) ? (MAX_L - LEN_W'(1)) : load_count_reg;
    assign pos_inc  = pos + LEN_W'(1);
    assign row_done = pos_inc >= eff_len;

    assign wr_en   = accept;
    assign wr_addr = pos[ADDR_W-1:0];
    assign wr_op   = operator_sample;
    assign wr_rec  = record_sample;

    // The pair that completes a row sends a job with the length and mode in force.
    assign job_push  = accept && row_done;
    assign job.len   = eff_len;
    assign job.half  = (eff_len >> 1) + LEN_W'(1);
    assign job.corr  = cfg.corr;

    always_comb
    begin
        load_count_next = load_count_reg;
        if (accept)
            load_count_next = row_done ? '0 : pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_count_reg <= '0;
        else
            load_count_reg <= load_count_next;
    end

endmodule

### rtl/ssc_job_fifo.sv
// Two-entry queue of row jobs between the front end and the engine.
module ssc_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssc_pkg::job_t push_job,
    input  logic          pop,
    output logic          job_valid,
    output ssc_pkg::job_t job,
    output logic [1:0]    count
);
    import ssc_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign job_valid = count_reg != 2'd0;
    assign job       = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Entries carry payload only and need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/ssc_engine.sv
// Engine: sample stores and one shared multiply-accumulate that computes a row.
module ssc_engine #(
    parameter int MAX_LEN = 64,
    parameter int ADDR_W  = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [ADDR_W-1:0]                    wr_addr,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  wr_op,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]  wr_rec,
    input  logic                                 job_valid,
    input  ssc_pkg::job_t                        job,
    output ssc_pkg::eng_status_t                 status,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [ssc_pkg::RESULT_W-1:0]  result_sample,
    output logic                                 last_result
);
    import ssc_pkg::*;

    // Sample stores.
    logic signed [SAMPLE_W-1:0] op_mem  [MAX_LEN];
    logic signed [SAMPLE_W-1:0] rec_mem [MAX_LEN];

    // Issue stage.
    job_t              job_reg;
    logic              active_reg;
    logic              active_next;
    logic [ADDR_W-1:0] s_reg;
    logic [ADDR_W-1:0] s_next;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] j_next;
    logic signed [IDX_W-1:0] s_x;
    logic signed [IDX_W-1:0] j_x;
    logic signed [IDX_W-1:0] len_x;
    logic signed [IDX_W-1:0] half_x;
    logic signed [IDX_W-1:0] idx;
    logic              idx_ok;
    logic              s_last;
    logic              j_last;
    logic              adv;
    logic              issue;
    logic              start;

    // Read stage.
    logic v1_reg, first1_reg, lastj1_reg, lastrow1_reg, ok1_reg;
    logic signed [SAMPLE_W-1:0] op_rd_reg;
    logic signed [SAMPLE_W-1:0] rec_rd_reg;

    // Product stage.
    logic v2_reg, first2_reg, lastj2_reg, lastrow2_reg, ok2_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Accumulate and output.
    logic signed [RESULT_W-1:0] acc_reg;
    logic signed [RESULT_W-1:0] sum;
    logic signed [RESULT_W-1:0] prod_ext;
    logic signed [RESULT_W-1:0] result_reg;
    logic                       last_reg;
    logic                       result_valid_reg;
    logic                       result_valid_next;

    // The whole pipeline holds while a finished result waits.
    assign adv   = !result_valid_reg || !result_stall;
    assign issue = active_reg && adv;
    assign start = !active_reg && job_valid;

    assign status.busy = active_reg;
    assign status.pop  = start;

    // Record index of the current term.
    assign s_x    = $signed({{(IDX_W - ADDR_W){1'b0}}, s_reg});
    assign j_x    = $signed({{(IDX_W - ADDR_W){1'b0}}, j_reg});
    assign len_x  = $signed({1'b0, job_reg.len});
    assign half_x = $signed({1'b0, job_reg.half});

    always_comb
    begin
        if (job_reg.corr)
            idx = s_x + half_x - $signed(IDX_W'(1)) - j_x;
        else
            idx = j_x + len_x - half_x - s_x;
    end

    assign idx_ok = !idx[IDX_W-1] && (idx < len_x);
    assign s_last = s_x == (len_x - $signed(IDX_W'(1)));
    assign j_last = j_x == (len_x - $signed(IDX_W'(1)));

    // Term and output sample counters.
    always_comb
    begin
        active_next = active_reg;
        s_next      = s_reg;
        j_next      = j_reg;
        if (start)
        begin
            active_next = 1'b1;
            s_next      = '0;
            j_next      = '0;
        end
        else if (issue)
        begin
            if (s_last)
            begin
                s_next = '0;
                if (j_last)
                    active_next = 1'b0;
                else
                    j_next = j_reg + ADDR_W'(1);
            end
            else
            begin
                s_next = s_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            s_reg      <= '0;
            j_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            s_reg      <= s_next;
            j_reg      <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            job_reg <= job;
    end

    // Store writes from the front end.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            op_mem[wr_addr]  <= wr_op;
            rec_mem[wr_addr] <= wr_rec;
        end
    end

    // Registered store reads; an out-of-range term reads any entry and is dropped later.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            op_rd_reg  <= op_mem[s_reg];
            rec_rd_reg <= rec_mem[idx[ADDR_W-1:0]];
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    // Term tags and product.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            first1_reg   <= s_reg == '0;
            lastj1_reg   <= s_last;
            lastrow1_reg <= s_last && j_last;
            ok1_reg      <= idx_ok;
            first2_reg   <= first1_reg;
            lastj2_reg   <= lastj1_reg;
            lastrow2_reg <= lastrow1_reg;
            ok2_reg      <= ok1_reg;
            prod_reg     <= op_rd_reg * rec_rd_reg;
        end
    end

    // Accumulate one term; the first term of a sample restarts the sum.
    assign prod_ext = {{(RESULT_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum      = (first2_reg ? '0 : acc_reg) + (ok2_reg ? prod_ext : '0);

    always_ff @(posedge clk)
    begin
        if (adv && v2_reg)
        begin
            acc_reg <= sum;
            if (lastj2_reg)
            begin
                result_reg <= sum;
                last_reg   <= lastrow2_reg;
            end
        end
    end

    assign result_valid_next = (adv && v2_reg && lastj2_reg)
                             ? 1'b1 : (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    assign result_valid  = result_valid_reg;
    assign result_sample = result_reg;
    assign last_result   = last_reg;

endmodule

### rtl/same_size_convolution.sv
// Top level of the same-size convolution and cross-correlation block.
//
// A row of L sample pairs (L = trace_length clamped to 2..MAX_LEN) is loaded at one
// item per cycle when not stalled. The item that completes the row queues a job, and
// the engine then runs L*L terms through one shared 16x16 multiply-accumulate, one
// term per cycle while the result side does not stall, reading both sample stores
// through their single read ports. Terms pass through the read, product and accumulate
// registers, and results leave one per output sample, with last_result on the final
// one. Input is stalled while a job is queued or being issued. Configuration writes
// are always ready.
module same_size_convolution #(
    parameter int MAX_LEN = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]    operator_sample,
    input  logic signed [ssc_pkg::SAMPLE_W-1:0]    record_sample,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [ssc_pkg::RESULT_W-1:0]    result_sample,
    output logic                                   last_result
);
    import ssc_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    cfg_t              cfg_reg;
    logic              hold;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic signed [SAMPLE_W-1:0] wr_op;
    logic signed [SAMPLE_W-1:0] wr_rec;
    logic              job_push;
    job_t              push_job;
    logic              job_valid;
    job_t              job;
    logic [1:0]        job_count;
    eng_status_t       eng_status;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.len  <= LEN_W'(64);
            cfg_reg.corr <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TRACE_LENGTH:   cfg_reg.len  <= cfg_data;
                REG_CORRELATE_MODE: cfg_reg.corr <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Loading waits until the stores are no longer being read for a row.
    assign hold = job_valid || eng_status.busy;

    ssc_front #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .hold            (hold),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .operator_sample (operator_sample),
        .record_sample   (record_sample),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_op           (wr_op),
        .wr_rec          (wr_rec),
        .job_push        (job_push),
        .job             (push_job)
    );

    ssc_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .pop       (eng_status.pop),
        .job_valid (job_valid),
        .job       (job),
        .count     (job_count)
    );

    ssc_engine #(
        .MAX_LEN (MAX_LEN),
        .ADDR_W  (ADDR_W)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_op         (wr_op),
        .wr_rec        (wr_rec),
        .job_valid     (job_valid),
        .job           (job),
        .status        (eng_status),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_sample (result_sample),
        .last_result   (last_result)
    );

    // A job is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> job_count != 2'd2)
        else $error("job pushed into a full queue");

    // A popped job starts the engine on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.pop |=> eng_status.busy)
        else $error("engine did not start after job pop");

    // Loading stops right after a row is complete.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |=> item_stall)
        else $error("input not stalled after row completion");

    // The engine never takes a job while it is still issuing a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.busy |-> !eng_status.pop)
        else $error("job popped while engine busy");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the same-size convolution and correlation block.
module testbench;
    import ssc_pkg::*;

    localparam int MAX_LEN       = 64;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] op;
        logic signed [SAMPLE_W-1:0] rec;
    } sample_pair_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] sample;
        logic                       last;
    } row_result_t;

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       cfg_valid       = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index       = '0;
    logic [CFG_DATA_W-1:0]      cfg_data        = '0;
    logic                       item_valid      = 1'b0;
    logic                       item_stall;
    logic signed [SAMPLE_W-1:0] operator_sample = '0;
    logic signed [SAMPLE_W-1:0] record_sample   = '0;
    logic                       result_valid;
    logic                       result_stall    = 1'b0;
    logic signed [RESULT_W-1:0] result_sample;
    logic                       last_result;

    // Items waiting to be sent and row samples waiting to come out.
    sample_pair_t pair_queue[$];
    row_result_t  awaited_results[$];

    // Shadow copy of the row stores, the load position and the registers.
    logic signed [SAMPLE_W-1:0] op_row  [MAX_LEN];
    logic signed [SAMPLE_W-1:0] rec_row [MAX_LEN];
    int                         fill_count  = 0;
    logic [LEN_W-1:0]           shadow_len  = 7'd64;
    logic                       shadow_corr = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;

    same_size_convolution #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .operator_sample(operator_sample),
        .record_sample  (record_sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_sample  (result_sample),
        .last_result    (last_result)
    );

    // The clock runs with a 10 ns period.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Store one pair and, when it completes the row, queue the centered
    // convolution or correlation of the row.
    task automatic absorb_pair(input logic signed [SAMPLE_W-1:0] op,
                               input logic signed [SAMPLE_W-1:0] rec);
        int          len;
        int          pos;
        int          half;
        int          idx;
        longint      acc;
        row_result_t res;
        if (shadow_len < 2)
            len = 2;
        else if (shadow_len > MAX_LEN)
            len = MAX_LEN;
        else
            len = int'(shadow_len);
        pos = (fill_count >= MAX_LEN) ? MAX_LEN - 1 : fill_count;
        op_row[pos]  = op;
        rec_row[pos] = rec;
        if (pos + 1 < len)
        begin
            fill_count = pos + 1;
        end
        else
        begin
            fill_count = 0;
            half = len / 2 + 1;
            for (int j = 0; j < len; j++)
            begin
                acc = 0;
                for (int s = 0; s < len; s++)
                begin
                    if (shadow_corr)
                        idx = s + half - 1 - j;
                    else
                        idx = j + len - half - s;
                    if (idx >= 0 && idx < len)
                        acc += longint'(op_row[s]) * longint'(rec_row[idx]);
                end
                res.sample = acc[RESULT_W-1:0];
                res.last   = (j == len - 1);
                awaited_results.push_back(res);
            end
        end
    endtask

    // Item driver: the payload holds while stalled, and gaps are random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid      <= 1'b0;
            operator_sample <= '0;
            record_sample   <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                absorb_pair(operator_sample, record_sample);
            if (!item_valid || !item_stall)
            begin
                if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_valid      <= 1'b1;
                    operator_sample <= pair_queue[0].op;
                    record_sample   <= pair_queue[0].rec;
                    void'(pair_queue.pop_front());
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls; each accepted result is checked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result %0d, last %0b",
                             $time, result_sample, last_result);
                    error_count++;
                end
                else
                begin
                    if (result_sample !== awaited_results[0].sample)
                    begin
                        $display("%0t: result_sample expected %0d, got %0d",
                                 $time, awaited_results[0].sample, result_sample);
                        error_count++;
                    end
                    if (last_result !== awaited_results[0].last)
                    begin
                        $display("%0t: last_result expected %0b, got %0b",
                                 $time, awaited_results[0].last, last_result);
                        error_count++;
                    end
                    void'(awaited_results.pop_front());
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Wait until every item is sent and every row sample has come out.
    task automatic wait_quiet();
        while (pair_queue.size() != 0 || item_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_TRACE_LENGTH)
            shadow_len = data;
        else if (index == REG_CORRELATE_MODE)
            shadow_corr = data[0];
    endtask

    // Registers change only once the block has drained. The unused upper
    // bits of the mode word are random.
    task automatic set_config(input logic [LEN_W-1:0] len, input logic corr);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word    = CFG_DATA_W'($urandom);
        mode_word[0] = corr;
        wait_quiet();
        write_reg(REG_TRACE_LENGTH, len);
        write_reg(REG_CORRELATE_MODE, mode_word);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 46;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 46;
            end
            default:
            begin
                send_idle_pct  = 29;
                recv_stall_pct = 29;
            end
        endcase
    endtask

    // Mix of full-scale extremes, values near zero and uniform samples.
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return $signed(SAMPLE_W'(int'($urandom_range(15)) - 8));
            default: return $signed(SAMPLE_W'($urandom));
        endcase
    endfunction

    task automatic push_pair(input logic signed [SAMPLE_W-1:0] op,
                             input logic signed [SAMPLE_W-1:0] rec);
        sample_pair_t p;
        p.op  = op;
        p.rec = rec;
        pair_queue.push_back(p);
    endtask

    task automatic push_random(input int count);
        repeat (count) push_pair(rand_sample(), rand_sample());
    endtask

    // Stimulus sequence.
    initial
    begin
        int items;
        int len_pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // One full row with the configuration left from reset.
        push_random(MAX_LEN);

        // Lengths of zero and one behave as two, in both modes.
        set_config(7'd0, 1'b0);
        push_pair(16'sh7FFF, 16'sh7FFF);
        push_pair(16'sh8000, 16'sh8000);
        set_config(7'd1, 1'b1);
        push_pair(16'sh8000, 16'sh7FFF);
        push_pair(16'sh7FFF, 16'sh8000);

        // Largest magnitude products summed over a short row.
        set_config(7'd3, 1'b0);
        repeat (3) push_pair(16'sh8000, 16'sh8000);
        set_config(7'd2, 1'b1);
        push_pair(16'sh0000, 16'sh0000);
        push_pair(16'shFFFF, 16'sh0001);

        // Length shortened mid-row: the next item closes the row at once.
        set_config(7'd5, 1'b0);
        push_pair(16'sd1, 16'sd2);
        push_pair(16'sd3, 16'sd4);
        push_pair(-16'sd5, -16'sd6);
        set_config(7'd2, 1'b0);
        push_pair(16'sd7, 16'sd8);

        // Mode switched mid-row: the mode at the closing item applies.
        set_config(7'd4, 1'b0);
        push_pair(16'sh1234, -16'sh0F0F);
        push_pair(-16'sh4000, 16'sh7FFF);
        set_config(7'd4, 1'b1);
        push_pair(16'sh8000, 16'sh2222);
        push_pair(16'sh0101, -16'sh0001);

        // Random phases over lengths, modes and idling patterns.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       len_pick = 127;
                1:       len_pick = 65;
                2:       len_pick = 1;
                default: len_pick = ($urandom_range(9) == 0) ? $urandom_range(64, 127)
                                                              : $urandom_range(0, 16);
            endcase
            set_config(LEN_W'(len_pick), 1'($urandom_range(1)));
            set_idle(p % 4);
            items = (len_pick >= MAX_LEN) ? MAX_LEN : $urandom_range(6, 14);
            push_random(items);
        end

        // The sender holds off after each batch until all results are back.
        set_config(7'd8, 1'($urandom_range(1)));
        set_idle(3);
        repeat (4)
        begin
            push_random(8);
            wait_quiet();
        end

        wait_quiet();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
